/* rtl/spp_pkg.sv */
// Shared constants, payload types and register codes of the stereo point projector.
package spp_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int NUM_COEF      = 21;
    localparam int HOMO_BASE     = 12;
    localparam int NUM_PROJ      = 12;
    localparam int NUM_HOMO      = 9;
    localparam int QUO_BITS      = 32;
    localparam int DIV_LAT       = QUO_BITS + 2;
    localparam int DIV_W         = 64 + QUO_BITS + 1;
    localparam int COEF_IDX_W    = 5;
    localparam logic [15:0] X_LIMIT_RESET = 16'd280;
    localparam logic [15:0] Y_LIMIT_RESET = 16'd220;

    typedef enum logic
    {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } cfg_index_t;

    typedef enum logic
    {
        KIND_LOAD  = 1'b0,
        KIND_POINT = 1'b1
    } kind_t;

    typedef struct packed
    {
        logic                  kind;
        logic [COEF_IDX_W-1:0] coef_index;
        logic signed [31:0]    coef_value;
        logic signed [31:0]    point_x;
        logic signed [31:0]    point_y;
        logic signed [31:0]    point_z;
    } in_item_t;

    typedef struct packed
    {
        logic signed [31:0] left_x;
        logic signed [31:0] left_y;
        logic signed [31:0] right_x;
        logic signed [31:0] right_y;
    } out_item_t;

endpackage

/* rtl/stereo_point_projector.sv */
// Top level of the stereo point projector: coefficient store, projection pipeline, output register.
//
// Input channel in_valid/in_stall/in_data: each beat either loads one of 21 Q16.16
// coefficients (kind 0; 0..11 projection matrix, 12..20 homography, row-major) or
// carries one 3D point (kind 1). A load takes effect at once for every later point.
// Output channel out_valid/out_stall/out_data: one beat with the left and right
// pixel for each point whose w values are non-zero, whose homography is not all
// zero and whose pixels lie below x_limit and y_limit; other points give nothing.
// Configuration: cfg_we writes cfg_data to x_limit (index 0) or y_limit (index 1).
// Throughput: one beat per cycle while the output is not stalled. An input beat
// reaches the output through five multiply/sum stages, the 34-stage bit-per-stage
// dividers and the output register.
// Reset clears the coefficient store to zero, the limits to 280 and 220 and
// empties the pipeline. A stalled output holds its beat and freezes the whole
// pipeline; in_stall is raised for that time and nothing is lost or repeated.
module stereo_point_projector
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  spp_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output spp_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  spp_pkg::cfg_index_t cfg_index,
    input  logic [15:0]        cfg_data
);
    import spp_pkg::*;

    logic                      en;
    logic                      in_fire;
    logic                      h_zero;

    logic [15:0]               x_limit_reg;
    logic [15:0]               y_limit_reg;
    logic signed [31:0]        coef_reg [0:NUM_COEF-1];

    logic                      s1_v_reg;
    logic signed [31:0]        s1_p_reg [0:2];
    logic signed [31:0]        s1_a_reg [0:NUM_PROJ-1];
    logic signed [31:0]        s1_h_reg [0:NUM_HOMO-1];

    logic                      s2_v_reg;
    logic signed [63:0]        s2_m_reg [0:NUM_PROJ-1];
    logic signed [31:0]        s2_h_reg [0:NUM_HOMO-1];

    logic                      s3_v_reg;
    logic signed [31:0]        s3_lv_reg [0:2];
    logic signed [31:0]        s3_h_reg  [0:NUM_HOMO-1];

    logic                      s4_v_reg;
    logic signed [63:0]        s4_m_reg  [0:NUM_HOMO-1];
    logic signed [31:0]        s4_lv_reg [0:2];

    logic                      s5_v_reg;
    logic signed [63:0]        s5_rv_reg [0:2];
    logic signed [31:0]        s5_lv_reg [0:2];

    logic [DIV_LAT-1:0]        dv_reg;
    logic                      s5_ok;
    logic signed [31:0]        q [0:3];
    logic                      in_bounds;

    logic                      out_valid_reg;
    out_item_t                 out_data_reg;

    logic signed [65:0]        lsum [0:2];
    logic signed [63:0]        rsum [0:2];
    logic signed [63:0]        xb;
    logic signed [63:0]        yb;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;
    assign in_fire  = in_valid && en;

    always_comb
    begin
        h_zero = 1'b1;
        for (int j = HOMO_BASE; j < NUM_COEF; j++)
            if (coef_reg[j] != '0)
                h_zero = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_X_LIMIT: x_limit_reg <= cfg_data;
                CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default:     x_limit_reg <= x_limit_reg;
            endcase
        end
    end

    for (genvar i = 0; i < NUM_COEF; i++)
    begin : g_coef
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                coef_reg[i] <= '0;
            else if (in_fire && in_data.kind == KIND_LOAD
                     && in_data.coef_index == COEF_IDX_W'(i))
                coef_reg[i] <= in_data.coef_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            s4_v_reg <= 1'b0;
            s5_v_reg <= 1'b0;
            dv_reg   <= '0;
        end
        else if (en)
        begin
            s1_v_reg <= in_fire && in_data.kind == KIND_POINT && !h_zero;
            s2_v_reg <= s1_v_reg;
            s3_v_reg <= s2_v_reg;
            s4_v_reg <= s3_v_reg;
            s5_v_reg <= s4_v_reg;
            dv_reg   <= {dv_reg[DIV_LAT-2:0], s5_ok};
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            lsum[r] = '0;
            for (int j = 0; j < 4; j++)
                lsum[r] = lsum[r] + 66'(s2_m_reg[r*4+j] >>> FRAC_BITS);
            rsum[r] = '0;
            for (int j = 0; j < 3; j++)
                rsum[r] = rsum[r] + (s4_m_reg[r*3+j] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_p_reg[0] <= in_data.point_x;
            s1_p_reg[1] <= in_data.point_y;
            s1_p_reg[2] <= in_data.point_z;
            for (int i = 0; i < NUM_PROJ; i++)
                s1_a_reg[i] <= coef_reg[i];
            for (int i = 0; i < NUM_HOMO; i++)
                s1_h_reg[i] <= coef_reg[HOMO_BASE+i];

            for (int r = 0; r < 3; r++)
            begin
                for (int j = 0; j < 3; j++)
                    s2_m_reg[r*4+j] <= 64'(s1_a_reg[r*4+j]) * 64'(s1_p_reg[j]);
                s2_m_reg[r*4+3] <= 64'(s1_a_reg[r*4+3]) <<< FRAC_BITS;
            end
            s2_h_reg <= s1_h_reg;

            for (int r = 0; r < 3; r++)
            begin
                if (lsum[r] > 66'sh0_7FFF_FFFF)
                    s3_lv_reg[r] <= 32'sh7FFF_FFFF;
                else if (lsum[r] < -66'sh0_8000_0000)
                    s3_lv_reg[r] <= 32'sh8000_0000;
                else
                    s3_lv_reg[r] <= lsum[r][31:0];
            end
            s3_h_reg <= s2_h_reg;

            for (int r = 0; r < 3; r++)
                for (int j = 0; j < 3; j++)
                    s4_m_reg[r*3+j] <= 64'(s3_h_reg[r*3+j]) * 64'(s3_lv_reg[j]);
            s4_lv_reg <= s3_lv_reg;

            s5_rv_reg <= rsum;
            s5_lv_reg <= s4_lv_reg;
        end
    end

    assign s5_ok = s5_v_reg && s5_lv_reg[2] != '0 && s5_rv_reg[2] != '0;

    spp_div u_div_lx (.clk(clk), .en(en), .num(64'(s5_lv_reg[0])), .den(64'(s5_lv_reg[2])),
                      .quo(q[0]));
    spp_div u_div_ly (.clk(clk), .en(en), .num(64'(s5_lv_reg[1])), .den(64'(s5_lv_reg[2])),
                      .quo(q[1]));
    spp_div u_div_rx (.clk(clk), .en(en), .num(s5_rv_reg[0]), .den(s5_rv_reg[2]),
                      .quo(q[2]));
    spp_div u_div_ry (.clk(clk), .en(en), .num(s5_rv_reg[1]), .den(s5_rv_reg[2]),
                      .quo(q[3]));

    assign xb = $signed(64'(x_limit_reg) << FRAC_BITS);
    assign yb = $signed(64'(y_limit_reg) << FRAC_BITS);
    assign in_bounds = (64'(q[0]) < xb) && (64'(q[2]) < xb)
                    && (64'(q[1]) < yb) && (64'(q[3]) < yb);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DIV_LAT-1] && in_bounds;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg.left_x  <= q[0];
            out_data_reg.left_y  <= q[1];
            out_data_reg.right_x <= q[2];
            out_data_reg.right_y <= q[3];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

/* rtl/spp_div.sv */
// Pipelined signed fixed-point divider, one quotient bit per stage, saturating.
module spp_div
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic signed [31:0] quo
);
    import spp_pkg::*;

    logic                       neg_a_reg;
    logic [63:0]                a_a_reg;
    logic [63:0]                d_a_reg;

    logic [DIV_W-1:0]           r_reg   [0:QUO_BITS];
    logic [63:0]                d_reg   [0:QUO_BITS];
    logic [QUO_BITS-1:0]        q_reg   [0:QUO_BITS];
    logic                       neg_reg [0:QUO_BITS];
    logic                       ovf_reg [0:QUO_BITS];

    logic [DIV_W-1:0]           n_full;
    logic [DIV_W-1:0]           d_top;
    logic [QUO_BITS-1:0]        mag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_a_reg <= num[63] ^ den[63];
            a_a_reg   <= num[63] ? (64'd0 - num) : num;
            d_a_reg   <= den[63] ? (64'd0 - den) : den;
        end
    end

    assign n_full = DIV_W'(a_a_reg) << FRAC_BITS;
    assign d_top  = DIV_W'(d_a_reg) << QUO_BITS;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= n_full;
            d_reg[0]   <= d_a_reg;
            q_reg[0]   <= '0;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= (n_full >= d_top);
        end
    end

    for (genvar k = 1; k <= QUO_BITS; k++)
    begin : g_stage
        localparam int BIT = QUO_BITS - k;
        logic [DIV_W-1:0] t;
        logic             take;
        assign t    = DIV_W'(d_reg[k-1]) << BIT;
        assign take = (r_reg[k-1] >= t);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[k]   <= take ? (r_reg[k-1] - t) : r_reg[k-1];
                q_reg[k]   <= q_reg[k-1] | (take ? (QUO_BITS'(1) << BIT) : '0);
                d_reg[k]   <= d_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign mag = q_reg[QUO_BITS];

    always_comb
    begin
        if (ovf_reg[QUO_BITS])
            quo = neg_reg[QUO_BITS] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else if (neg_reg[QUO_BITS])
            quo = (mag > 32'h8000_0000) ? 32'sh8000_0000 : $signed(32'd0 - mag);
        else
            quo = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
    end

endmodule
